### rtl/core/kwls_pkg.sv
// ---------------------------------------------------------------------------
// kwls_pkg: shared definitions for the keyed window latency statistics block
// Table sizes, sample array type, sequencer states and small helpers.
// ---------------------------------------------------------------------------
package kwls_pkg;

  localparam int CTX_N   = 16;
  localparam int SER_N   = 32;
  localparam int WIN_MAX = 8;

  localparam int CTX_AW  = $clog2(CTX_N);
  localparam int SER_AW  = $clog2(SER_N);
  localparam int SLOT_W  = $clog2(WIN_MAX);
  localparam int FILL_W  = $clog2(WIN_MAX + 1);
  localparam int MEM_AW  = SER_AW + SLOT_W;
  localparam int MEM_N   = SER_N * WIN_MAX;

  localparam logic [3:0] WIN_RESET = 4'd7;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_EPOCH  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CSCAN, S_SSCAN, S_DECIDE, S_COMMIT, S_QCHK,
    S_LOAD, S_SORT1, S_STAT, S_DEV, S_SORT2, S_RESULT
  } state_t;

  // Samples carry a top bit so that padding sorts above every real sample.
  typedef logic [31:0] smp_arr_t [WIN_MAX];

  localparam logic [31:0] PAD = 32'hFFFF_FFFF;

  // Position of the 90th percentile in a sorted window of n samples.
  // The index is floor((9n + 9) / 10) - 1; the divide by ten is a multiply by
  // 205 and a shift, which is exact for the small values met here.
  function automatic logic [SLOT_W-1:0] p90_idx(input logic [FILL_W-1:0] n);
    int t;
    t = (((9 * int'(n) + 9) * 205) >> 11) - 1;
    if (t >= int'(n)) t = int'(n) - 1;
    if (t < 0) t = 0;
    return SLOT_W'(t);
  endfunction

endpackage

### rtl/core/keyed_window_latency_stats.sv
// ---------------------------------------------------------------------------
// keyed_window_latency_stats
// Keyed table of latency series with a sliding window per series; records
// samples, resets epochs and answers median, MAD and p90 queries.
// ---------------------------------------------------------------------------
// Channel  | handshake            | word
// in       | in_valid / in_stall  | op, handle, revision, context, samples
// out      | out_valid / out_stall| status and statistics
// cfg      | cfg_we               | cfg_wdata (window length)
//
// A record or epoch reset runs a context scan and a series scan, each through one
// key comparator, then a decide step and one commit step.
// A query follows the scans with a window read from the sample RAMs and two
// 8-pass sorts through one odd-even compare stage.
// Reset clears all valid bits at once; no clearing pass is needed.
// The input is stalled while a word is in work; a finished result waits in
// the output register while the next word is already taken.
module keyed_window_latency_stats (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic        handle_ok,
  input  logic [15:0] handle_provider,
  input  logic [15:0] handle_generation,
  input  logic [31:0] handle_resource,
  input  logic [63:0] revision,
  input  logic [63:0] workload,
  input  logic [7:0]  device_code,
  input  logic [31:0] work_count,
  input  logic signed [31:0] wall_sample,
  input  logic signed [31:0] cpu_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        available,
  output logic [31:0] epoch_out,
  output logic [3:0]  sample_count,
  output logic [30:0] median_wall,
  output logic [30:0] mad_wall,
  output logic [30:0] p90_wall,
  output logic [30:0] median_cpu,
  output logic [31:0] age_out
);

  localparam int CAW = kwls_pkg::CTX_AW;
  localparam int SAW = kwls_pkg::SER_AW;
  localparam int SLW = kwls_pkg::SLOT_W;
  localparam int FW  = kwls_pkg::FILL_W;
  localparam int WM  = kwls_pkg::WIN_MAX;

  kwls_pkg::state_t state, state_next;

  logic [3:0] win_len;

  // Latched word
  kwls_pkg::op_t l_op;
  logic [63:0]   l_hk;
  logic [63:0]   l_rev;
  logic [63:0]   l_wl;
  logic [13:0]   l_extra;
  logic [30:0]   l_wall;
  logic [30:0]   l_cpu;

  // Context table
  logic          ctx_valid [kwls_pkg::CTX_N];
  logic [63:0]   ctx_key   [kwls_pkg::CTX_N];
  logic [13:0]   ctx_extra [kwls_pkg::CTX_N];
  logic [31:0]   ctx_cnt   [kwls_pkg::CTX_N];

  // Series table
  logic          ser_valid [kwls_pkg::SER_N];
  logic [63:0]   ser_hk    [kwls_pkg::SER_N];
  logic [63:0]   ser_rev   [kwls_pkg::SER_N];
  logic [CAW-1:0] ser_ctx  [kwls_pkg::SER_N];
  logic [31:0]   ser_epoch [kwls_pkg::SER_N];
  logic [31:0]   ser_last  [kwls_pkg::SER_N];
  logic [FW-1:0] ser_fill  [kwls_pkg::SER_N];
  logic [SLW-1:0] ser_wp   [kwls_pkg::SER_N];

  // Sample RAMs
  logic [30:0] wall_mem [kwls_pkg::MEM_N];
  logic [30:0] cpu_mem  [kwls_pkg::MEM_N];
  logic [30:0] rd_wall, rd_cpu;
  logic [kwls_pkg::MEM_AW-1:0] raddr;

  logic [CAW-1:0] cidx, c_hit_idx, c_free_idx;
  logic [SAW-1:0] sidx, s_hit_idx, s_free_idx;
  logic c_hit, c_free, s_hit, s_free, new_ctx, new_ser;

  logic [FW-1:0]  q_n;
  logic [3:0]     ld_cnt;
  logic [SLW-1:0] sort_cnt;

  kwls_pkg::smp_arr_t w_arr, c_arr, w_sorted, c_sorted;

  // Pending result
  logic [1:0]  p_status;
  logic        p_avail;
  logic [31:0] p_epoch;
  logic [3:0]  p_count;
  logic [30:0] p_medw, p_p90, p_medc;
  logic [31:0] p_age;

  logic        accept;
  logic [5:0]  cls;
  logic [FW-1:0] eff_w;
  logic        ctx_match, ser_match, is_rec;
  logic [31:0] cnt_new;
  logic [FW-1:0] fill_old, fill_inc;
  logic [SLW-1:0] wp_old;

  function automatic logic [30:0] median_of(input kwls_pkg::smp_arr_t a,
                                            input logic [FW-1:0] n);
    logic [SLW-1:0] m;
    logic [31:0]    s;
    m = SLW'(n >> 1);
    s = a[m] + a[m - SLW'(1)];
    if (n[0]) return a[m][30:0];
    return s[31:1];
  endfunction

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != kwls_pkg::S_IDLE);

  always_comb begin
    cls = '0;
    for (int i = 0; i < 32; i++) begin
      if (work_count[i]) cls = 6'(i);
    end
  end

  always_comb begin
    if (win_len == 4'd0) eff_w = FW'(1);
    else if (int'(win_len) > WM) eff_w = FW'(WM);
    else eff_w = FW'(win_len);
  end

  assign ctx_match = ctx_valid[cidx] && ctx_key[cidx] == l_wl && ctx_extra[cidx] == l_extra;
  assign ser_match = ser_valid[sidx] && c_hit && ser_hk[sidx] == l_hk
                     && ser_rev[sidx] == l_rev && ser_ctx[sidx] == c_hit_idx;

  assign is_rec   = (l_op == kwls_pkg::OP_RECORD);
  assign cnt_new  = (new_ctx ? 32'd0 : ctx_cnt[cidx]) + {31'd0, is_rec};
  assign fill_old = new_ser ? '0 : ser_fill[sidx];
  assign wp_old   = new_ser ? '0 : ser_wp[sidx];
  assign fill_inc = (fill_old + FW'(1) > eff_w) ? eff_w : fill_old + FW'(1);

  assign raddr = {sidx, ser_wp[sidx] - SLW'(1) - ld_cnt[SLW-1:0]};

  // One odd-even transposition pass, shared by both windows.
  always_comb begin
    w_sorted = w_arr;
    c_sorted = c_arr;
    for (int i = 0; i < WM - 1; i++) begin
      if (((i & 1) == 1) == sort_cnt[0]) begin
        if (w_arr[i] > w_arr[i+1]) begin
          w_sorted[i] = w_arr[i+1];
          w_sorted[i+1] = w_arr[i];
        end
        if (c_arr[i] > c_arr[i+1]) begin
          c_sorted[i] = c_arr[i+1];
          c_sorted[i+1] = c_arr[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= kwls_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      kwls_pkg::S_IDLE: begin
        if (accept) begin
          if (op == kwls_pkg::OP_NONE) state_next = kwls_pkg::S_RESULT;
          else if (op == kwls_pkg::OP_RECORD && (!handle_ok || revision == 64'd0
                   || work_count == 32'd0 || wall_sample[31]))
            state_next = kwls_pkg::S_RESULT;
          else state_next = kwls_pkg::S_CSCAN;
        end
      end
      kwls_pkg::S_CSCAN:
        if (cidx == CAW'(kwls_pkg::CTX_N - 1)) state_next = kwls_pkg::S_SSCAN;
      kwls_pkg::S_SSCAN:
        if (sidx == SAW'(kwls_pkg::SER_N - 1)) state_next = kwls_pkg::S_DECIDE;
      kwls_pkg::S_DECIDE: begin
        if (l_op == kwls_pkg::OP_QUERY)
          state_next = (c_hit && s_hit) ? kwls_pkg::S_QCHK : kwls_pkg::S_RESULT;
        else if ((!c_hit && !c_free) || (!s_hit && !s_free))
          state_next = kwls_pkg::S_RESULT;
        else state_next = kwls_pkg::S_COMMIT;
      end
      kwls_pkg::S_COMMIT: state_next = kwls_pkg::S_RESULT;
      kwls_pkg::S_QCHK:
        state_next = (ser_fill[sidx] == '0) ? kwls_pkg::S_RESULT : kwls_pkg::S_LOAD;
      kwls_pkg::S_LOAD:
        if (ld_cnt == 4'(WM)) state_next = kwls_pkg::S_SORT1;
      kwls_pkg::S_SORT1:
        if (sort_cnt == SLW'(WM - 1)) state_next = kwls_pkg::S_STAT;
      kwls_pkg::S_STAT: state_next = kwls_pkg::S_DEV;
      kwls_pkg::S_DEV: state_next = kwls_pkg::S_SORT2;
      kwls_pkg::S_SORT2:
        if (sort_cnt == SLW'(WM - 1)) state_next = kwls_pkg::S_RESULT;
      kwls_pkg::S_RESULT:
        if (!out_valid || !out_stall) state_next = kwls_pkg::S_IDLE;
      default: state_next = kwls_pkg::S_IDLE;
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= kwls_pkg::WIN_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < kwls_pkg::CTX_N; i++) ctx_valid[i] <= 1'b0;
      for (int i = 0; i < kwls_pkg::SER_N; i++) ser_valid[i] <= 1'b0;
    end else begin
      if (cfg_we) win_len <= cfg_wdata;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == kwls_pkg::S_RESULT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      if (state == kwls_pkg::S_COMMIT) begin
        ctx_valid[cidx] <= 1'b1;
        ser_valid[sidx] <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      kwls_pkg::S_IDLE: begin
        if (accept) begin
          l_op    <= kwls_pkg::op_t'(op);
          l_hk    <= {handle_provider, handle_generation, handle_resource};
          l_rev   <= revision;
          l_wl    <= workload;
          l_extra <= {device_code, cls};
          l_wall  <= wall_sample[30:0];
          l_cpu   <= cpu_sample[31] ? 31'd0 : cpu_sample[30:0];
          cidx    <= '0;
          c_hit   <= 1'b0;
          c_free  <= 1'b0;
          p_status <= kwls_pkg::ST_IGNORED;
          p_avail <= 1'b0;
          p_epoch <= '0;
          p_count <= '0;
          p_medw  <= '0;
          p_p90   <= '0;
          p_medc  <= '0;
          p_age   <= '0;
        end
      end
      kwls_pkg::S_CSCAN: begin
        if (ctx_match && !c_hit) begin
          c_hit <= 1'b1;
          c_hit_idx <= cidx;
        end
        if (!ctx_valid[cidx] && !c_free) begin
          c_free <= 1'b1;
          c_free_idx <= cidx;
        end
        cidx <= cidx + CAW'(1);
        sidx <= '0;
        s_hit <= 1'b0;
        s_free <= 1'b0;
      end
      kwls_pkg::S_SSCAN: begin
        if (ser_match && !s_hit) begin
          s_hit <= 1'b1;
          s_hit_idx <= sidx;
        end
        if (!ser_valid[sidx] && !s_free) begin
          s_free <= 1'b1;
          s_free_idx <= sidx;
        end
        sidx <= sidx + SAW'(1);
      end
      kwls_pkg::S_DECIDE: begin
        cidx <= c_hit ? c_hit_idx : c_free_idx;
        sidx <= s_hit ? s_hit_idx : s_free_idx;
        new_ctx <= !c_hit;
        new_ser <= !s_hit;
        if (l_op != kwls_pkg::OP_QUERY && ((!c_hit && !c_free) || (!s_hit && !s_free)))
          p_status <= kwls_pkg::ST_FULL;
      end
      kwls_pkg::S_COMMIT: begin
        p_status <= kwls_pkg::ST_DONE;
        ctx_cnt[cidx] <= cnt_new;
        if (new_ctx) begin
          ctx_key[cidx] <= l_wl;
          ctx_extra[cidx] <= l_extra;
        end
        if (new_ser) begin
          ser_hk[sidx] <= l_hk;
          ser_rev[sidx] <= l_rev;
          ser_ctx[sidx] <= cidx;
        end
        ser_last[sidx] <= cnt_new;
        if (is_rec) begin
          if (new_ser) ser_epoch[sidx] <= 32'd1;
          ser_fill[sidx] <= fill_inc;
          ser_wp[sidx] <= wp_old + SLW'(1);
          wall_mem[{sidx, wp_old}] <= l_wall;
          cpu_mem[{sidx, wp_old}] <= l_cpu;
        end else begin
          ser_epoch[sidx] <= (new_ser ? 32'd1 : ser_epoch[sidx]) + 32'd1;
          ser_fill[sidx] <= '0;
          ser_wp[sidx] <= wp_old;
        end
      end
      kwls_pkg::S_QCHK: begin
        p_status <= kwls_pkg::ST_DONE;
        q_n <= ser_fill[sidx];
        p_epoch <= ser_epoch[sidx];
        p_count <= 4'(ser_fill[sidx]);
        if (ser_fill[sidx] != '0) begin
          p_avail <= 1'b1;
          p_age <= (ctx_cnt[cidx] >= ser_last[sidx]) ? ctx_cnt[cidx] - ser_last[sidx] : '0;
        end
        ld_cnt <= '0;
      end
      kwls_pkg::S_LOAD: begin
        // Read data arrives in the cycle after its address.
        if (ld_cnt != 4'd0) begin
          for (int i = 0; i < WM - 1; i++) begin
            w_arr[i] <= w_arr[i+1];
            c_arr[i] <= c_arr[i+1];
          end
          w_arr[WM-1] <= (ld_cnt <= 4'(q_n)) ? {1'b0, rd_wall} : kwls_pkg::PAD;
          c_arr[WM-1] <= (ld_cnt <= 4'(q_n)) ? {1'b0, rd_cpu} : kwls_pkg::PAD;
        end
        ld_cnt <= ld_cnt + 4'd1;
        sort_cnt <= '0;
      end
      kwls_pkg::S_SORT1, kwls_pkg::S_SORT2: begin
        w_arr <= w_sorted;
        c_arr <= c_sorted;
        sort_cnt <= sort_cnt + SLW'(1);
      end
      kwls_pkg::S_STAT: begin
        p_medw <= median_of(w_arr, q_n);
        p_p90 <= w_arr[kwls_pkg::p90_idx(q_n)][30:0];
        p_medc <= median_of(c_arr, q_n);
      end
      kwls_pkg::S_DEV: begin
        for (int i = 0; i < WM; i++) begin
          if (i < int'(q_n)) begin
            w_arr[i] <= (w_arr[i][30:0] >= p_medw) ? {1'b0, w_arr[i][30:0] - p_medw}
                                                   : {1'b0, p_medw - w_arr[i][30:0]};
          end
        end
        sort_cnt <= '0;
      end
      kwls_pkg::S_RESULT: begin
        if (!out_valid || !out_stall) begin
          status <= p_status;
          available <= p_avail;
          epoch_out <= p_epoch;
          sample_count <= p_count;
          median_wall <= p_medw;
          mad_wall <= (p_avail) ? median_of(w_arr, q_n) : '0;
          p90_wall <= p_p90;
          median_cpu <= p_medc;
          age_out <= p_age;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_wall <= wall_mem[raddr];
    rd_cpu <= cpu_mem[raddr];
  end

`ifndef SYNTHESIS
  a_out_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == kwls_pkg::S_RESULT))
    else $error("result word appeared outside the result step");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_count <= 4'(WM)))
    else $error("sample count beyond window size");

  a_full_not_avail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == kwls_pkg::ST_FULL) |-> !available)
    else $error("table full result marked available");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == kwls_pkg::S_COMMIT) |=> (ser_fill[$past(sidx)] <= FW'(WM)))
    else $error("series fill beyond window size");
`endif

endmodule

### tb/kwls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwls_checker
// Watches both channels of the latency statistics block, keeps its own copy
// of the series tables, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module kwls_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic        handle_ok,
  input  logic [15:0] handle_provider,
  input  logic [15:0] handle_generation,
  input  logic [31:0] handle_resource,
  input  logic [63:0] revision,
  input  logic [63:0] workload,
  input  logic [7:0]  device_code,
  input  logic [31:0] work_count,
  input  logic [31:0] wall_sample,
  input  logic [31:0] cpu_sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic        available,
  input  logic [31:0] epoch_out,
  input  logic [3:0]  sample_count,
  input  logic [30:0] median_wall,
  input  logic [30:0] mad_wall,
  input  logic [30:0] p90_wall,
  input  logic [30:0] median_cpu,
  input  logic [31:0] age_out,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  st;
    logic        avail;
    logic [31:0] epoch;
    logic [3:0]  cnt;
    logic [30:0] med;
    logic [30:0] mad;
    logic [30:0] p90;
    logic [30:0] cmed;
    logic [31:0] age;
  } summary_t;

  summary_t    expected_summaries[$];
  logic [3:0]  win_len;
  bit          c_used [kwls_pkg::CTX_N];
  logic [63:0] c_wl [kwls_pkg::CTX_N];
  logic [13:0] c_extra [kwls_pkg::CTX_N];
  logic [31:0] c_count [kwls_pkg::CTX_N];
  bit          s_used [kwls_pkg::SER_N];
  logic [63:0] s_hk [kwls_pkg::SER_N];
  logic [63:0] s_rev [kwls_pkg::SER_N];
  int          s_ctx [kwls_pkg::SER_N];
  logic [31:0] s_epoch [kwls_pkg::SER_N];
  logic [31:0] s_last [kwls_pkg::SER_N];
  int          s_fill [kwls_pkg::SER_N];
  logic [30:0] s_wall [kwls_pkg::SER_N][kwls_pkg::WIN_MAX];
  logic [30:0] s_cpu [kwls_pkg::SER_N][kwls_pkg::WIN_MAX];

  function automatic logic [5:0] unit_class(logic [31:0] wc);
    logic [5:0] b;
    b = 0;
    for (int i = 1; i < 32; i++) if (wc[i]) b = 6'(i);
    return b;
  endfunction

  function automatic int find_ctx(logic [63:0] wl, logic [13:0] ex);
    for (int i = 0; i < kwls_pkg::CTX_N; i++)
      if (c_used[i] && c_wl[i] == wl && c_extra[i] == ex) return i;
    return -1;
  endfunction

  function automatic int find_series(logic [63:0] hk, logic [63:0] rv, int ci);
    for (int i = 0; i < kwls_pkg::SER_N; i++)
      if (s_used[i] && s_hk[i] == hk && s_rev[i] == rv && s_ctx[i] == ci) return i;
    return -1;
  endfunction

  function automatic int first_free_series();
    for (int i = 0; i < kwls_pkg::SER_N; i++) if (!s_used[i]) return i;
    return -1;
  endfunction

  // Finds or allocates the context and the series; false when a table is full.
  function automatic bit claim(logic [63:0] wl, logic [13:0] ex, logic [63:0] hk,
                               logic [63:0] rv, output int ci, output int si);
    bit fresh;
    fresh = 0;
    si = -1;
    ci = find_ctx(wl, ex);
    if (ci < 0) begin
      fresh = 1;
      for (int i = kwls_pkg::CTX_N - 1; i >= 0; i--) if (!c_used[i]) ci = i;
      if (ci < 0) return 0;
    end
    if (!fresh) si = find_series(hk, rv, ci);
    if (si < 0) begin
      si = first_free_series();
      if (si < 0) return 0;
      s_used[si] = 1; s_hk[si] = hk; s_rev[si] = rv; s_ctx[si] = ci;
      s_epoch[si] = 1; s_last[si] = 0; s_fill[si] = 0;
    end
    if (fresh) begin
      c_used[ci] = 1; c_wl[ci] = wl; c_extra[ci] = ex; c_count[ci] = 0;
    end
    return 1;
  endfunction

  function automatic void sort_window(ref logic [30:0] a[kwls_pkg::WIN_MAX], input int n);
    logic [30:0] t;
    for (int i = 0; i < n; i++)
      for (int j = 0; j + 1 < n - i; j++)
        if (a[j] > a[j+1]) begin
          t = a[j]; a[j] = a[j+1]; a[j+1] = t;
        end
  endfunction

  function automatic logic [30:0] middle(ref logic [30:0] a[kwls_pkg::WIN_MAX],
                                         input int n);
    logic [31:0] s;
    if (n % 2) return a[n/2];
    s = {1'b0, a[n/2-1]} + {1'b0, a[n/2]};
    return s[31:1];
  endfunction

  function automatic summary_t summarise_word();
    summary_t r;
    logic [63:0] hk;
    logic [13:0] ex;
    logic [30:0] a[kwls_pkg::WIN_MAX], d[kwls_pkg::WIN_MAX], m;
    int ci, si, n, w, p;
    r = '0;
    hk = {handle_provider, handle_generation, handle_resource};
    ex = {device_code, unit_class(work_count)};
    case (kwls_pkg::op_t'(op))
      kwls_pkg::OP_RECORD: begin
        if (!handle_ok || revision == 0 || work_count == 0 || wall_sample[31]) begin
          r.st = kwls_pkg::ST_IGNORED;
        end else if (!claim(workload, ex, hk, revision, ci, si)) begin
          r.st = kwls_pkg::ST_FULL;
        end else begin
          c_count[ci] += 1;
          s_last[si] = c_count[ci];
          w = (win_len == 0) ? 1 : (win_len > kwls_pkg::WIN_MAX) ? kwls_pkg::WIN_MAX
                                                                 : int'(win_len);
          n = s_fill[si];
          if (n < kwls_pkg::WIN_MAX) n++;
          else for (int i = 0; i + 1 < kwls_pkg::WIN_MAX; i++) begin
            s_wall[si][i] = s_wall[si][i+1]; s_cpu[si][i] = s_cpu[si][i+1];
          end
          s_wall[si][n-1] = wall_sample[30:0];
          s_cpu[si][n-1] = cpu_sample[31] ? 31'd0 : cpu_sample[30:0];
          while (n > w) begin
            for (int i = 0; i + 1 < n; i++) begin
              s_wall[si][i] = s_wall[si][i+1]; s_cpu[si][i] = s_cpu[si][i+1];
            end
            n--;
          end
          s_fill[si] = n;
          r.st = kwls_pkg::ST_DONE;
        end
      end
      kwls_pkg::OP_EPOCH: begin
        if (!claim(workload, ex, hk, revision, ci, si)) r.st = kwls_pkg::ST_FULL;
        else begin
          s_epoch[si] += 1;
          s_fill[si] = 0;
          s_last[si] = c_count[ci];
          r.st = kwls_pkg::ST_DONE;
        end
      end
      kwls_pkg::OP_QUERY: begin
        ci = find_ctx(workload, ex);
        si = (ci < 0) ? -1 : find_series(hk, revision, ci);
        if (si < 0) r.st = kwls_pkg::ST_IGNORED;
        else begin
          n = s_fill[si];
          r.st = kwls_pkg::ST_DONE;
          r.epoch = s_epoch[si];
          r.cnt = 4'(n);
          if (n > 0) begin
            r.avail = 1;
            a = s_wall[si];
            sort_window(a, n);
            m = middle(a, n);
            r.med = m;
            for (int i = 0; i < n; i++) d[i] = (a[i] >= m) ? a[i] - m : m - a[i];
            sort_window(d, n);
            r.mad = middle(d, n);
            p = (9 * n + 9) / 10 - 1;
            if (p >= n) p = n - 1;
            r.p90 = a[p];
            a = s_cpu[si];
            sort_window(a, n);
            r.cmed = middle(a, n);
            r.age = (c_count[ci] >= s_last[si]) ? c_count[ci] - s_last[si] : 32'd0;
          end
        end
      end
      default: r.st = kwls_pkg::ST_IGNORED;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    summary_t e, g;
    if (rst) begin
      errors <= 0;
      pending <= 0;
      win_len = kwls_pkg::WIN_RESET;
      for (int i = 0; i < kwls_pkg::CTX_N; i++) c_used[i] = 0;
      for (int i = 0; i < kwls_pkg::SER_N; i++) s_used[i] = 0;
      expected_summaries.delete();
    end else begin
      if (out_valid && !out_stall) begin
        g = '{status, available, epoch_out, sample_count, median_wall, mad_wall,
              p90_wall, median_cpu, age_out};
        if (expected_summaries.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, g);
          errors <= errors + 1;
        end else begin
          e = expected_summaries.pop_front();
          if (e !== g) begin
            $display("%0t: result mismatch: expected st=%0d av=%0d ep=%0d n=%0d med=%0d",
                     $time, e.st, e.avail, e.epoch, e.cnt, e.med);
            $display("  mad=%0d p90=%0d cmed=%0d age=%0d", e.mad, e.p90, e.cmed, e.age);
            $display("  actual st=%0d av=%0d ep=%0d n=%0d med=%0d mad=%0d p90=%0d",
                     g.st, g.avail, g.epoch, g.cnt, g.med, g.mad, g.p90);
            $display("  cmed=%0d age=%0d", g.cmed, g.age);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_summaries.insert(expected_summaries.size(), summarise_word());
      if (cfg_we) win_len = cfg_wdata;
      pending <= expected_summaries.size();
    end
  end

endmodule

### tb/keyed_window_latency_stats_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_window_latency_stats_tb
// Drives record, epoch reset, query and no-op words into the latency statistics
// block under several idling phases and window lengths; a checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module keyed_window_latency_stats_tb;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [3:0]  cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  op = 0;
  logic        handle_ok = 0;
  logic [15:0] handle_provider = 0;
  logic [15:0] handle_generation = 0;
  logic [31:0] handle_resource = 0;
  logic [63:0] revision = 0;
  logic [63:0] workload = 0;
  logic [7:0]  device_code = 0;
  logic [31:0] work_count = 0;
  logic signed [31:0] wall_sample = 0;
  logic signed [31:0] cpu_sample = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status;
  logic        available;
  logic [31:0] epoch_out;
  logic [3:0]  sample_count;
  logic [30:0] median_wall, mad_wall, p90_wall, median_cpu;
  logic [31:0] age_out;
  int          errors, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          quiet_cycles = 0;

  always #4 clk = ~clk;

  keyed_window_latency_stats dut (.*);
  kwls_checker chk (.*);

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The word stays valid after it is taken; the next word or an idle cycle
  // replaces it, so valid is written once per edge.
  task automatic send_word(logic [1:0] o, logic hok, logic [63:0] hk, logic [63:0] rv,
                           logic [63:0] wl, logic [7:0] dev, logic [31:0] wc,
                           logic [31:0] wall, logic [31:0] cpu);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    op <= o; handle_ok <= hok;
    {handle_provider, handle_generation, handle_resource} <= hk;
    revision <= rv; workload <= wl; device_code <= dev; work_count <= wc;
    wall_sample <= wall; cpu_sample <= cpu;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Keys are drawn from small pools, unless pool is zero, so that series are revisited often.
  task automatic random_word(int pool);
    logic [1:0]  o;
    logic [63:0] hk, rv, wl;
    logic [31:0] wc, wall, cpu;
    int r;
    r = $urandom_range(99);
    o = (r < 60) ? kwls_pkg::OP_RECORD : (r < 68) ? kwls_pkg::OP_EPOCH
      : (r < 97) ? kwls_pkg::OP_QUERY : kwls_pkg::OP_NONE;
    hk = (pool == 0) ? {$urandom, $urandom} : 64'(($urandom_range(3) * 64'h0001_0003_0000_0005));
    rv = (pool == 0) ? {$urandom, $urandom} : 64'($urandom_range(2));
    wl = (pool == 0) ? {$urandom, $urandom} : ($urandom_range(1) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd9);
    wc = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(3));
    wall = ($urandom_range(15) == 0) ? $urandom : ($urandom & 32'h0000_FFFF);
    cpu = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(4000));
    send_word(o, $urandom_range(15) != 0, hk, rv, wl, (pool == 0) ? 8'($urandom) : 8'd0,
              wc, wall, cpu);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_window(logic [3:0] len);
    cfg_wdata <= len; cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    logic [63:0] hk;
    int phase_len[4] = '{250, 250, 250, 500};
    int idle_sets[4][2] = '{'{0, 0}, '{82, 0}, '{0, 82}, '{30, 30}};
    logic [3:0] lens[5] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    hk = 64'hFFFF_0000_FFFF_FFFF;
    // Directed part: ignored records, extremes, even and odd windows, queries, epoch resets, a no-op.
    send_word(kwls_pkg::OP_QUERY, 1, hk, 1, 0, 0, 1, 0, 0);
    send_word(kwls_pkg::OP_RECORD, 0, hk, 1, 0, 0, 1, 5, 5);
    send_word(kwls_pkg::OP_RECORD, 1, hk, 0, 0, 0, 1, 5, 5);
    send_word(kwls_pkg::OP_RECORD, 1, hk, 1, 0, 0, 0, 5, 5);
    send_word(kwls_pkg::OP_RECORD, 1, hk, 1, 0, 0, 1, 32'h8000_0000, 5);
    send_word(kwls_pkg::OP_RECORD, 1, hk, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              8'hFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(kwls_pkg::OP_RECORD, 1, hk, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(kwls_pkg::OP_QUERY, 0, hk, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              8'hFF, 32'hC000_0000, 0, 0);
    for (int i = 0; i < 9; i++) begin
      send_word(kwls_pkg::OP_RECORD, 1, 0, 1, 0, 0, 2, 32'(i * 37 % 11) << 8, 32'(i));
      if (i == 1 || i == 6 || i == 8) send_word(kwls_pkg::OP_QUERY, 1, 0, 1, 0, 0, 3, 0, 0);
    end
    send_word(kwls_pkg::OP_EPOCH, 0, 0, 1, 0, 0, 2, 0, 0);
    send_word(kwls_pkg::OP_QUERY, 1, 0, 1, 0, 0, 2, 0, 0);
    send_word(kwls_pkg::OP_EPOCH, 0, 7, 7, 7, 7, 7, 0, 0);
    send_word(kwls_pkg::OP_NONE, 1, 0, 1, 0, 0, 1, 0, 0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_sets[ph][0];
      recv_stall_pct = idle_sets[ph][1];
      for (int k = 0; k < phase_len[ph]; k++) begin
        random_word((k % 10 == 0) ? 0 : 1);
        if (k % 60 == 59) begin
          drain();
          set_window(lens[$urandom_range(4)]);
        end
      end
      drain();
      set_window(lens[ph]);
    end
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### keyed_window_latency_stats.f
rtl/core/kwls_pkg.sv
rtl/core/keyed_window_latency_stats.sv
tb/kwls_checker.sv
tb/keyed_window_latency_stats_tb.sv
